/* hw/rtl/fvcrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator package
// Shared constants, status codes, register indexes and the byte-wide
// CRC-16 (poly 0x1021, MSB first) update function.
// ----------------------------------------------------------------------------
package fvcrc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int HDR_LEN  = 8;
   localparam int TAIL_LEN = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic [15:0] MAGIC_RESET     = 16'h0000;
   localparam logic [7:0]  VERSION_RESET   = 8'd1;
   localparam logic [7:0]  TYPE_MAX_RESET  = 8'd5;
   localparam logic [11:0] MAX_PLEN_RESET  = 12'd246;
   localparam logic        EXACT_RESET     = 1'b1;
   localparam logic [12:0] CELL_SIZE_RESET = 13'd256;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNCATED = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_VERSION   = 3'd3,
      ST_TYPE      = 3'd4,
      ST_LENGTH    = 3'd5,
      ST_CRC       = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      CSR_MAGIC     = 3'd0,
      CSR_VERSION   = 3'd1,
      CSR_TYPE_MAX  = 3'd2,
      CSR_MAX_PLEN  = 3'd3,
      CSR_EXACT     = 3'd4,
      CSR_CELL_SIZE = 3'd5
   } csr_index_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/frame_validator_crc16_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator with CRC-16 check
// Checks one received buffer, delivered a byte per item, and reports a
// single verdict with the header fields after its last byte.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one byte per item with req_last on the final byte
// of a buffer. The rsp_ channel carries one verdict per buffer: status and,
// on a good frame, the header type, id and payload length (zero otherwise).
// The csr_ channel writes the six registers by index; it is always ready and
// writes should be made while no buffer is in flight.
// A verdict passes from the input register into the output register and
// appears on rsp_ once the last byte is accepted and the output is free.
// Throughput: one byte per cycle while req_ready is high; the byte-wide CRC
// update sits between the input register and the state. Reset clears the
// byte counter, header, CRC and all valid flags and loads the register
// defaults. When the receiver stalls, the verdict waits in the output
// register; bytes keep flowing until a second last byte must wait for it,
// and then req_ready drops.
module frame_validator_crc16_core #(
   parameter int COUNT_BITS = fvcrc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_msg_id,
   output logic [11:0] rsp_body_len,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fvcrc_pkg::*;

   localparam int CW = (COUNT_BITS > 18) ? COUNT_BITS : 18;

   logic [15:0] magic_cfg_ff;
   logic [7:0]  version_cfg_ff;
   logic [7:0]  type_max_cfg_ff;
   logic [11:0] max_plen_cfg_ff;
   logic        exact_cfg_ff;
   logic [12:0] cell_size_cfg_ff;

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [7:0]            hdr_ff [8];
   logic [15:0]           crc_ff;
   logic [15:0]           crc_in;
   logic [15:0]           wcrc_ff;
   logic [15:0]           wcrc_in;
   logic                  hdr_we;

   logic        out_valid_ff;
   logic [2:0]  out_status_ff;
   logic [7:0]  out_type_ff;
   logic [15:0] out_id_ff;
   logic [11:0] out_plen_ff;

   logic                  out_free;
   logic                  s1_go;
   logic                  sat;
   logic [COUNT_BITS-1:0] count_inc;
   logic [CW-1:0]         idx_x;
   logic [CW-1:0]         len_x;
   logic [CW-1:0]         body_end;
   logic [15:0]           hdr_magic;
   logic [15:0]           hdr_id;
   logic [15:0]           hdr_plen;
   status_type            status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff     <= MAGIC_RESET;
         version_cfg_ff   <= VERSION_RESET;
         type_max_cfg_ff  <= TYPE_MAX_RESET;
         max_plen_cfg_ff  <= MAX_PLEN_RESET;
         exact_cfg_ff     <= EXACT_RESET;
         cell_size_cfg_ff <= CELL_SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAGIC:     magic_cfg_ff     <= csr_wdata;
            CSR_VERSION:   version_cfg_ff   <= csr_wdata[7:0];
            CSR_TYPE_MAX:  type_max_cfg_ff  <= csr_wdata[7:0];
            CSR_MAX_PLEN:  max_plen_cfg_ff  <= csr_wdata[11:0];
            CSR_EXACT:     exact_cfg_ff     <= csr_wdata[0];
            CSR_CELL_SIZE: cell_size_cfg_ff <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last;
      end
   end

   assign hdr_magic = {hdr_ff[1], hdr_ff[0]};
   assign hdr_id    = {hdr_ff[5], hdr_ff[4]};
   assign hdr_plen  = {hdr_ff[7], hdr_ff[6]};
   assign sat       = &count_ff;
   assign count_inc = sat ? count_ff : count_ff + 1'b1;
   assign idx_x     = CW'(count_ff);
   assign len_x     = CW'(count_inc);
   assign body_end  = CW'(hdr_plen) + CW'(HDR_LEN);

   always_comb begin
      crc_in  = crc_ff;
      wcrc_in = wcrc_ff;
      hdr_we  = 1'b0;
      if (!sat) begin
         if (idx_x < CW'(HDR_LEN)) begin
            hdr_we = 1'b1;
            crc_in = crc_byte(crc_ff, s1_byte_ff);
         end else if (idx_x < body_end) begin
            crc_in = crc_byte(crc_ff, s1_byte_ff);
         end else if (idx_x == body_end) begin
            wcrc_in = {wcrc_ff[15:8], s1_byte_ff};
         end else if (idx_x == body_end + CW'(1)) begin
            wcrc_in = {s1_byte_ff, wcrc_ff[7:0]};
         end
      end
      count_in = count_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         wcrc_ff  <= 16'h0000;
         for (int i = 0; i < 8; i++) begin
            hdr_ff[i] <= 8'h00;
         end
      end else if (s1_go) begin
         if (s1_last_ff) begin
            count_ff <= '0;
            crc_ff   <= CRC_INIT;
            wcrc_ff  <= 16'h0000;
            for (int i = 0; i < 8; i++) begin
               hdr_ff[i] <= 8'h00;
            end
         end else begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            wcrc_ff  <= wcrc_in;
            if (hdr_we) begin
               hdr_ff[count_ff[2:0]] <= s1_byte_ff;
            end
         end
      end
   end

   // The last byte can only touch the header or the running CRC in buffers
   // that end up truncated, so those checks use the stored values directly.
   always_comb begin
      priority if (len_x < CW'(HDR_LEN + TAIL_LEN)) begin
         status = ST_TRUNCATED;
      end else if (hdr_magic != magic_cfg_ff) begin
         status = ST_MAGIC;
      end else if (hdr_ff[2] != version_cfg_ff) begin
         status = ST_VERSION;
      end else if (hdr_ff[3] > type_max_cfg_ff) begin
         status = ST_TYPE;
      end else if (hdr_plen > 16'(max_plen_cfg_ff)) begin
         status = ST_LENGTH;
      end else if (body_end + CW'(TAIL_LEN) > len_x) begin
         status = ST_TRUNCATED;
      end else if (exact_cfg_ff && (len_x != CW'(cell_size_cfg_ff))) begin
         status = ST_LENGTH;
      end else if (crc_ff != wcrc_in) begin
         status = ST_CRC;
      end else begin
         status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         out_status_ff <= status;
         if (status == ST_OK) begin
            out_type_ff <= hdr_ff[3];
            out_id_ff   <= hdr_id;
            out_plen_ff <= hdr_plen[11:0];
         end else begin
            out_type_ff <= 8'h00;
            out_id_ff   <= 16'h0000;
            out_plen_ff <= 12'h000;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_frame_type = out_type_ff;
   assign rsp_msg_id     = out_id_ff;
   assign rsp_body_len   = out_plen_ff;

endmodule

/* hw/rtl/fvcrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame validator port checker
// Watches the verdict channel of the frame validator for stall, code range,
// field clearing and reset behavior.
// ----------------------------------------------------------------------------
module fvcrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_frame_type,
   input logic [15:0] rsp_msg_id,
   input logic [11:0] rsp_body_len
);
   import fvcrc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_msg_id) && $stable(rsp_frame_type) && $stable(rsp_body_len))
      else $error("Verdict changed while stalled.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_CRC)
      else $error("Verdict code out of range.");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_frame_type == 8'h00 && rsp_msg_id == 16'h0000 && rsp_body_len == 12'h000)
      else $error("Header fields reported on a failed frame.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("Verdict valid right after reset.");

endmodule

bind frame_validator_crc16_core fvcrc_checker u_fvcrc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_frame_type (rsp_frame_type),
   .rsp_msg_id     (rsp_msg_id),
   .rsp_body_len   (rsp_body_len)
);
